/* src/amdfs_pkg.sv */
// ----------------------------------------------------------------------------
// amdfs_pkg
// Shared sizes, opcodes, types and helpers for the adjacency matrix
// depth-first walk block.
// ----------------------------------------------------------------------------
package amdfs_pkg;

    localparam int MAX_NODES   = 64;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = NODE_W + 1;
    localparam int CHUNK_W     = 8;
    localparam int CHUNK_LOG   = $clog2(CHUNK_W);
    localparam int CHUNK_IDX_W = NODE_W - CHUNK_LOG;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_WALK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef logic [NODE_W-1:0]    node_t;
    typedef logic [CNT_W-1:0]     count_t;
    typedef logic [MAX_NODES-1:0] row_t;

    typedef struct packed {
        node_t  node;
        count_t scan;
    } frame_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_cmd_t;

    typedef struct packed {
        logic  done;
        logic  found;
        node_t index;
    } scan_res_t;

    // position of the lowest set bit of one chunk
    function automatic logic [CHUNK_LOG-1:0] lowest_set(input logic [CHUNK_W-1:0] bits);
        logic [CHUNK_LOG-1:0] pos;
        pos = '0;
        for (int k = CHUNK_W - 1; k >= 0; k--)
        begin
            if (bits[k])
            begin
                pos = k[CHUNK_LOG-1:0];
            end
        end
        return pos;
    endfunction

endpackage

/* src/adjacency_matrix_dfs_order.sv */
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_order
// Undirected graph in an adjacency bit matrix with depth-first preorder walk.
//
//   channel | direction | beat contents
//   --------+-----------+------------------------------------------------
//   in      | in        | opcode, node_a, node_b
//   out     | out       | visited_node, last_of_walk, bad_start
//   cfg     | in        | node_count
//
// Add edge reads the row of node_a, writes it while reading the row of node_b,
// then writes that row; clear and unused opcodes finish on acceptance. A walk
// steps through accept or push, row read, candidate mask and at least one chunk
// of the shared scan unit per visited node, through pop, stack read, candidate
// mask and scan per return to a parent, then a final pop and beat, plus a scan
// step per empty 8-node chunk; the single row read port and chunk scan set them.
// Reset clears the row valid bits at once; no sweep is needed.
// Input ready is low while an item is in progress; a stalled output
// holds the walk one node behind, since the last node is only known at the end.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_order (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              opcode,
    input  logic [5:0]              node_a,
    input  logic [5:0]              node_b,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [5:0]              visited_node,
    output logic                    last_of_walk,
    output logic                    bad_start,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [6:0]              node_count
);
    import amdfs_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADD_WA = 4'd1;
    localparam logic [3:0] S_ADD_WB = 4'd2;
    localparam logic [3:0] S_LOAD   = 4'd3;
    localparam logic [3:0] S_CAND   = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_PUSH   = 4'd6;
    localparam logic [3:0] S_POP    = 4'd7;
    localparam logic [3:0] S_POPW   = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_BAD    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    count_t     node_count_reg;
    count_t     node_count_next;
    row_t       visited_reg;
    row_t       visited_next;
    node_t      na_reg;
    node_t      na_next;
    node_t      nb_reg;
    node_t      nb_next;
    node_t      top_node_reg;
    node_t      top_node_next;
    count_t     top_scan_reg;
    count_t     top_scan_next;
    node_t      pend_reg;
    node_t      pend_next;
    node_t      found_reg;
    node_t      found_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    node_t      out_node_reg;
    node_t      out_node_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       out_bad_reg;
    logic       out_bad_next;

    count_t     n_eff;
    logic       in_beat;
    logic       out_free;

    logic       adj_rd_en;
    node_t      adj_rd_addr;
    logic       adj_wr_en;
    node_t      adj_wr_addr;
    row_t       adj_wr_row;
    logic       adj_clear;
    row_t       adj_row;

    stack_cmd_t stk_cmd;
    frame_t     stk_push;
    frame_t     stk_top;
    logic       stk_empty;

    logic       scan_start;
    row_t       cand;
    scan_res_t  scan_res;

    amdfs_adj_mem u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adj_rd_en),
        .rd_addr (adj_rd_addr),
        .wr_en   (adj_wr_en),
        .wr_addr (adj_wr_addr),
        .wr_row  (adj_wr_row),
        .clear   (adj_clear),
        .rd_row  (adj_row)
    );

    amdfs_stack u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (stk_cmd),
        .push_frame (stk_push),
        .top_frame  (stk_top),
        .empty      (stk_empty)
    );

    amdfs_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scan_start),
        .cand        (cand),
        .first_chunk (top_scan_reg[NODE_W-1:CHUNK_LOG]),
        .res         (scan_res)
    );

    assign n_eff     = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                            : node_count_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // unvisited neighbors of the top node from its scan position up to the node count
    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++)
        begin
            cand[k] = adj_row[k] && !visited_reg[k] && (CNT_W'(k) < n_eff)
                      && (CNT_W'(k) >= top_scan_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = cfg_valid ? node_count : node_count_reg;
        visited_next    = visited_reg;
        na_next         = na_reg;
        nb_next         = nb_reg;
        top_node_next   = top_node_reg;
        top_scan_next   = top_scan_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_node_next   = out_node_reg;
        out_last_next   = out_last_reg;
        out_bad_next    = out_bad_reg;

        adj_rd_en   = 1'b0;
        adj_rd_addr = top_node_reg;
        adj_wr_en   = 1'b0;
        adj_wr_addr = na_reg;
        adj_wr_row  = adj_row | (row_t'(1) << nb_reg);
        adj_clear   = 1'b0;
        stk_cmd     = '0;
        stk_push    = '{node: top_node_reg, scan: CNT_W'(found_reg) + CNT_W'(1)};
        scan_start  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    case (opcode)
                        OP_ADD:
                        begin
                            adj_rd_en   = 1'b1;
                            adj_rd_addr = node_a;
                            na_next     = node_a;
                            nb_next     = node_b;
                            state_next  = S_ADD_WA;
                        end
                        OP_WALK:
                        begin
                            if (CNT_W'(node_a) >= n_eff)
                            begin
                                state_next = S_BAD;
                            end
                            else
                            begin
                                visited_next  = row_t'(1) << node_a;
                                pend_next     = node_a;
                                top_node_next = node_a;
                                top_scan_next = '0;
                                state_next    = S_LOAD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            adj_clear     = 1'b1;
                            visited_next  = '0;
                            stk_cmd.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD_WA:
            begin
                // a self loop reads the old row here and writes the same bits twice
                adj_wr_en   = 1'b1;
                adj_rd_en   = 1'b1;
                adj_rd_addr = nb_reg;
                state_next  = S_ADD_WB;
            end
            S_ADD_WB:
            begin
                adj_wr_en   = 1'b1;
                adj_wr_addr = nb_reg;
                adj_wr_row  = adj_row | (row_t'(1) << na_reg);
                state_next  = S_IDLE;
            end
            S_LOAD:
            begin
                adj_rd_en  = 1'b1;
                state_next = S_CAND;
            end
            S_CAND:
            begin
                scan_start = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_res.done)
                begin
                    found_next = scan_res.index;
                    state_next = scan_res.found ? S_PUSH : S_POP;
                end
            end
            S_PUSH:
            begin
                // the held node goes out only once a successor proves it is not last
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_node_next           = pend_reg;
                    out_last_next           = 1'b0;
                    out_bad_next            = 1'b0;
                    pend_next               = found_reg;
                    visited_next[found_reg] = 1'b1;
                    stk_cmd.push            = 1'b1;
                    top_node_next           = found_reg;
                    top_scan_next           = '0;
                    state_next              = S_LOAD;
                end
            end
            S_POP:
            begin
                if (stk_empty)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    stk_cmd.pop = 1'b1;
                    state_next  = S_POPW;
                end
            end
            S_POPW:
            begin
                top_node_next = stk_top.node;
                top_scan_next = stk_top.scan;
                adj_rd_en     = 1'b1;
                adj_rd_addr   = stk_top.node;
                state_next    = S_CAND;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = pend_reg;
                    out_last_next  = 1'b1;
                    out_bad_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_BAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = '0;
                    out_last_next  = 1'b1;
                    out_bad_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        top_node_reg <= top_node_next;
        top_scan_reg <= top_scan_next;
        pend_reg     <= pend_next;
        found_reg    <= found_next;
        out_node_reg <= out_node_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= CNT_W'(MAX_NODES);
            visited_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            visited_reg    <= visited_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign visited_node = out_node_reg;
    assign last_of_walk = out_last_reg;
    assign bad_start    = out_bad_reg;

endmodule

/* src/amdfs_adj_mem.sv */
// ----------------------------------------------------------------------------
// amdfs_adj_mem
// Adjacency row memory: one row per node, registered read, per-row valid
// bits so that a clear needs no sweep of the rows; an invalid row reads as zero.
// ----------------------------------------------------------------------------
module amdfs_adj_mem (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  amdfs_pkg::node_t rd_addr,
    input  logic            wr_en,
    input  amdfs_pkg::node_t wr_addr,
    input  amdfs_pkg::row_t  wr_row,
    input  logic            clear,
    output amdfs_pkg::row_t  rd_row
);
    import amdfs_pkg::*;

    row_t rows [MAX_NODES];
    row_t rd_data_reg;
    logic rd_valid_reg;
    logic rd_valid_next;
    row_t row_valid_reg;
    row_t row_valid_next;

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (clear)
        begin
            row_valid_next = '0;
        end
        else if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
        rd_valid_next = rd_en ? row_valid_reg[rd_addr] : rd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rows[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= rows[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* src/amdfs_stack.sv */
// ----------------------------------------------------------------------------
// amdfs_stack
// Walk stack of suspended frames (node, next neighbor to try) in a memory
// with registered read; popped frame is valid the cycle after the pop.
// ----------------------------------------------------------------------------
module amdfs_stack (
    input  logic                  clk,
    input  logic                  rst_n,
    input  amdfs_pkg::stack_cmd_t cmd,
    input  amdfs_pkg::frame_t     push_frame,
    output amdfs_pkg::frame_t     top_frame,
    output logic                  empty
);
    import amdfs_pkg::*;

    frame_t mem [MAX_NODES];
    frame_t rd_reg;
    count_t depth_reg;
    count_t depth_next;
    node_t  pop_addr;

    assign pop_addr = depth_reg[NODE_W-1:0] - NODE_W'(1);

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.clear)
        begin
            depth_next = '0;
        end
        else if (cmd.push)
        begin
            depth_next = depth_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            depth_next = depth_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[depth_reg[NODE_W-1:0]] <= push_frame;
        end
        if (cmd.pop)
        begin
            rd_reg <= mem[pop_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    assign top_frame = rd_reg;
    assign empty     = (depth_reg == '0);

endmodule

/* src/amdfs_scan.sv */
// ----------------------------------------------------------------------------
// amdfs_scan
// Shared neighbor search: walks a candidate word one 8-bit chunk per cycle
// and reports the lowest candidate index, or that there is none.
// ----------------------------------------------------------------------------
module amdfs_scan (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  amdfs_pkg::row_t                          cand,
    input  logic [amdfs_pkg::CHUNK_IDX_W-1:0]        first_chunk,
    output amdfs_pkg::scan_res_t                     res
);
    import amdfs_pkg::*;

    logic                   run_reg;
    logic                   run_next;
    row_t                   cand_reg;
    row_t                   cand_next;
    logic [CHUNK_IDX_W-1:0] chunk_reg;
    logic [CHUNK_IDX_W-1:0] chunk_next;
    logic [CHUNK_W-1:0]     chunk_bits;
    logic                   any_cand;

    assign chunk_bits = cand_reg[{chunk_reg, {CHUNK_LOG{1'b0}}} +: CHUNK_W];
    assign any_cand   = (cand_reg != '0);

    always_comb
    begin
        res.done  = run_reg && (!any_cand || (chunk_bits != '0));
        res.found = any_cand;
        res.index = {chunk_reg, lowest_set(chunk_bits)};

        run_next   = run_reg;
        cand_next  = cand_reg;
        chunk_next = chunk_reg;
        if (start)
        begin
            run_next   = 1'b1;
            cand_next  = cand;
            chunk_next = first_chunk;
        end
        else if (res.done)
        begin
            run_next = 1'b0;
        end
        else if (run_reg)
        begin
            // candidates below the start chunk are masked off, so a set bit lies ahead
            chunk_next = chunk_reg + CHUNK_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg  <= cand_next;
        chunk_reg <= chunk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

endmodule

/* tb/sv/adjacency_matrix_dfs_order_tb.sv */
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_order_tb
// Self-checking bench for the adjacency matrix depth-first walk block.
// Builds graphs through add-edge and clear commands and starts walks. It
// predicts every visited-node beat from its own copy of the matrix and the
// node count, and checks the output beats in order. It also sweeps the node
// count register through its extremes and a spread of values in between.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_order_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import amdfs_pkg::*;

    // opcode with no function in the block
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef logic [6:0] node_count_t;

    typedef struct {
        logic [1:0] op;
        node_t      a;
        node_t      b;
    } graph_cmd_t;

    typedef struct {
        node_t node;
        logic  last;
        logic  bad;
    } visit_beat_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [1:0] opcode       = OP_ADD;
    logic [5:0] node_a       = '0;
    logic [5:0] node_b       = '0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [5:0] visited_node;
    logic       last_of_walk;
    logic       bad_start;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic [6:0] node_count   = 7'd64;

    graph_cmd_t  cmd_pending [$];
    visit_beat_t visit_expect [$];
    row_t        links [MAX_NODES];
    count_t      nodes_in_use = 7'd64;

    int cmds_queued    = 0;
    int cmds_taken     = 0;
    int send_gap_pct   = 0;
    int take_stall_pct = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int errors         = 0;
    graph_cmd_t next_cmd;

    adjacency_matrix_dfs_order u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .node_a       (node_a),
        .node_b       (node_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .visited_node (visited_node),
        .last_of_walk (last_of_walk),
        .bad_start    (bad_start),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .node_count   (node_count)
    );

    always #6 clk = ~clk;

    // graph update and preorder walk for one accepted command
    function automatic void predict_walk(input logic [1:0] op, input node_t a, input node_t b);
        int          lim;
        int          depth;
        int          pos;
        int          found_at;
        int          emitted;
        row_t        seen;
        node_t       frame_node [MAX_NODES];
        int          frame_scan [MAX_NODES];
        visit_beat_t v;
        lim = (nodes_in_use < MAX_NODES) ? int'(nodes_in_use) : MAX_NODES;
        case (op)
            OP_ADD:
            begin
                links[a][b] = 1'b1;
                links[b][a] = 1'b1;
            end
            OP_CLEAR:
            begin
                foreach (links[r])
                begin
                    links[r] = '0;
                end
            end
            OP_WALK:
            begin
                if (a >= lim)
                begin
                    v.node = '0;
                    v.last = 1'b1;
                    v.bad  = 1'b1;
                    visit_expect.push_back(v);
                end
                else
                begin
                    seen    = '0;
                    seen[a] = 1'b1;
                    v.node  = a;
                    v.last  = 1'b0;
                    v.bad   = 1'b0;
                    visit_expect.push_back(v);
                    emitted       = 1;
                    frame_node[0] = a;
                    frame_scan[0] = 0;
                    depth         = 1;
                    while (depth > 0)
                    begin
                        found_at = -1;
                        for (pos = frame_scan[depth-1]; pos < lim && found_at < 0; pos++)
                        begin
                            if (links[frame_node[depth-1]][pos] && !seen[pos])
                            begin
                                found_at = pos;
                            end
                        end
                        if (found_at >= 0 && emitted < MAX_NODES && depth < MAX_NODES)
                        begin
                            frame_scan[depth-1] = found_at + 1;
                            seen[found_at]      = 1'b1;
                            v.node              = node_t'(found_at);
                            visit_expect.push_back(v);
                            emitted++;
                            frame_node[depth] = node_t'(found_at);
                            frame_scan[depth] = 0;
                            depth++;
                        end
                        else
                        begin
                            depth--;
                        end
                    end
                    visit_expect[visit_expect.size()-1].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_walk(opcode, node_a, node_b);
                cmds_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (cmd_pending.size() > 0 && $urandom_range(99) < send_gap_pct)
                begin
                    gap_left = $urandom_range(0, 6);
                    in_valid <= 1'b0;
                end
                else if (cmd_pending.size() > 0)
                begin
                    next_cmd = cmd_pending.pop_front();
                    in_valid <= 1'b1;
                    opcode   <= next_cmd.op;
                    node_a   <= next_cmd.a;
                    node_b   <= next_cmd.b;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (visit_expect.size() == 0)
                begin
                    $error("unexpected beat: visited_node %0d last_of_walk %0b bad_start %0b",
                           visited_node, last_of_walk, bad_start);
                    errors++;
                end
                else
                begin
                    automatic visit_beat_t want = visit_expect.pop_front();
                    if (visited_node !== want.node)
                    begin
                        $error("visited_node: expected %0d, got %0d", want.node, visited_node);
                        errors++;
                    end
                    if (last_of_walk !== want.last)
                    begin
                        $error("last_of_walk: expected %0b, got %0b", want.last, last_of_walk);
                        errors++;
                    end
                    if (bad_start !== want.bad)
                    begin
                        $error("bad_start: expected %0b, got %0b", want.bad, bad_start);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(99) < take_stall_pct)
            begin
                stall_left = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_cmd(input logic [1:0] op, input node_t a, input node_t b);
        graph_cmd_t c;
        c.op = op;
        c.a  = a;
        c.b  = b;
        cmd_pending.push_back(c);
        cmds_queued++;
    endtask

    task automatic wait_drained();
        while (!(cmds_taken == cmds_queued && visit_expect.size() == 0))
        begin
            @(posedge clk);
        end
    endtask

    // only while idle; add-edge beats give no result, so leave time for the last one
    task automatic set_node_count(input logic [6:0] value);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_valid  <= 1'b1;
        node_count <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        nodes_in_use = value;
    endtask

    // rounds of a likely clear, random edges mostly inside the scanned range, then a few walks
    task automatic queue_graph_session(input int budget);
        int    made;
        int    k;
        int    edges;
        int    span;
        node_t x;
        node_t y;
        span = (nodes_in_use == 0) ? 1 : ((nodes_in_use < MAX_NODES) ? int'(nodes_in_use)
                                                                        : MAX_NODES);
        made = 0;
        while (made < budget)
        begin
            if ($urandom_range(3) != 0)
            begin
                queue_cmd(OP_CLEAR, node_t'($urandom_range(63)), node_t'($urandom_range(63)));
                made++;
            end
            edges = $urandom_range(1, (span < 16) ? span + 3 : 16);
            for (k = 0; k < edges; k++)
            begin
                if ($urandom_range(9) != 0)
                begin
                    x = node_t'($urandom_range(span - 1));
                    y = node_t'($urandom_range(span - 1));
                end
                else
                begin
                    x = node_t'($urandom_range(63));
                    y = node_t'($urandom_range(63));
                end
                queue_cmd(OP_ADD, x, y);
                made++;
                if ($urandom_range(19) == 0)
                begin
                    queue_cmd(OP_SPARE, node_t'($urandom_range(63)), node_t'($urandom_range(63)));
                end
            end
            repeat ($urandom_range(1, 3))
            begin
                x = ($urandom_range(6) == 0) ? node_t'($urandom_range(63))
                                             : node_t'($urandom_range(span - 1));
                queue_cmd(OP_WALK, x, node_t'($urandom_range(63)));
                made++;
            end
        end
    endtask

    initial
    begin
        automatic logic [6:0] count_plan [10] = '{7'd8, 7'd64, 7'd2, 7'd9, 7'd33,
                                                  7'd127, 7'd63, 7'd16, 7'd1, 7'd0};
        node_t order_of [MAX_NODES];
        node_t t;
        int    j;
        int    k;
        foreach (links[r])
        begin
            links[r] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty graph, extremes, self loops, a small cycle, spare opcode
        queue_cmd(OP_WALK, 6'd0, 6'd63);
        queue_cmd(OP_WALK, 6'd63, 6'd0);
        queue_cmd(OP_ADD, 6'd0, 6'd63);
        queue_cmd(OP_ADD, 6'd63, 6'd63);
        queue_cmd(OP_ADD, 6'd0, 6'd1);
        queue_cmd(OP_ADD, 6'd1, 6'd2);
        queue_cmd(OP_ADD, 6'd2, 6'd0);
        queue_cmd(OP_ADD, 6'd5, 6'd5);
        queue_cmd(OP_WALK, 6'd0, 6'd0);
        queue_cmd(OP_WALK, 6'd63, 6'd21);
        queue_cmd(OP_WALK, 6'd5, 6'd42);
        queue_cmd(OP_SPARE, 6'd63, 6'd63);
        queue_cmd(OP_ADD, 6'd62, 6'd61);
        queue_cmd(OP_CLEAR, 6'd63, 6'd63);
        queue_cmd(OP_WALK, 6'd0, 6'd0);

        // zero count: every start is bad; edges still stored
        set_node_count(7'd0);
        queue_cmd(OP_WALK, 6'd0, 6'd0);
        queue_cmd(OP_WALK, 6'd63, 6'd0);
        queue_cmd(OP_ADD, 6'd3, 6'd40);

        // edge reaching past the count is not scanned
        set_node_count(7'd8);
        queue_cmd(OP_WALK, 6'd3, 6'd0);
        queue_cmd(OP_WALK, 6'd8, 6'd0);
        queue_cmd(OP_WALK, 6'd7, 6'd0);

        set_node_count(7'd1);
        queue_cmd(OP_WALK, 6'd0, 6'd0);
        queue_cmd(OP_WALK, 6'd1, 6'd0);

        set_node_count(7'd127);
        queue_cmd(OP_WALK, 6'd3, 6'd0);
        queue_cmd(OP_WALK, 6'd40, 6'd0);

        // random sessions over a spread of node counts
        foreach (count_plan[p])
        begin
            set_node_count(count_plan[p]);
            send_gap_pct   = $urandom_range(2) * 15;
            take_stall_pct = $urandom_range(2) * 15;
            queue_graph_session(10);
        end

        // one path through all nodes: deepest stack, longest walk
        set_node_count(7'd65);
        send_gap_pct   = 20;
        take_stall_pct = 20;
        for (k = 0; k < MAX_NODES; k++)
        begin
            order_of[k] = node_t'(k);
        end
        for (k = MAX_NODES - 1; k > 0; k--)
        begin
            j           = $urandom_range(k);
            t           = order_of[k];
            order_of[k] = order_of[j];
            order_of[j] = t;
        end
        queue_cmd(OP_CLEAR, 6'd0, 6'd0);
        for (k = 0; k < MAX_NODES - 1; k++)
        begin
            if ($urandom_range(1) == 0)
            begin
                queue_cmd(OP_ADD, order_of[k], order_of[k+1]);
            end
            else
            begin
                queue_cmd(OP_ADD, order_of[k+1], order_of[k]);
            end
        end
        queue_cmd(OP_WALK, order_of[0], 6'd0);
        queue_cmd(OP_WALK, node_t'($urandom_range(63)), 6'd0);

        // closing stretch runs without gaps or stalls
        set_node_count(node_count_t'($urandom_range(3, 20)));
        send_gap_pct   = 0;
        take_stall_pct = 0;
        queue_graph_session(25);

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0 && visit_expect.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
